// ----- src/vwht_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vwht_pkg
// Shared constants, types and the position hash for the vertex weld table.
// ----------------------------------------------------------------------------
package vwht_pkg;

    localparam int HASH_BITS    = 10;
    localparam int VERTEX_DEPTH = 1024;
    localparam int BUCKETS      = 1 << HASH_BITS;
    localparam int VIDX_W       = $clog2(VERTEX_DEPTH);
    localparam int LINK_W       = VIDX_W + 1;
    localparam int HB_W         = 4;
    localparam int NRM_W        = 18;
    localparam int DOT_W        = 40;
    localparam int OUT_IDX_W    = 10;

    localparam logic [31:0] HASH_ADD = 32'h1234_5678;
    localparam logic signed [DOT_W-1:0] DOT_LOW  = DOT_W'(64'h0000_fff0_0000);
    localparam logic signed [DOT_W-1:0] DOT_HIGH = DOT_W'(64'h0001_0010_0000);

    // classified request handed from front to back
    typedef struct packed {
        logic                    new_mesh;
        logic [HASH_BITS-1:0]    bucket;
        logic [31:0]             px;
        logic [31:0]             py;
        logic [31:0]             pz;
        logic [63:0]             uv;
        logic [3*NRM_W-1:0]      nrm;
    } req_t;

    // one add-rotate round with arithmetic right part
    function automatic logic [31:0] mix_round(input logic [31:0] v);
        logic [31:0] hi;
        begin
            hi = {{27{v[31]}}, v[31:27]};
            mix_round = v + HASH_ADD + ((v << 5) | hi);
        end
    endfunction

endpackage
`default_nettype wire

// ----- src/vwht_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vwht_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module vwht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- src/vwht_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vwht_front
// Accepts vertices, hashes positions (three rounds a cycle) and queues the
// classified request in a two-entry FIFO toward the back end.
// ----------------------------------------------------------------------------
module vwht_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [vwht_pkg::HB_W-1:0]    hash_bits,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         new_mesh,
    input  wire logic [31:0]                  pos_x,
    input  wire logic [31:0]                  pos_y,
    input  wire logic [31:0]                  pos_z,
    input  wire logic [31:0]                  tex_u,
    input  wire logic [31:0]                  tex_v,
    input  wire logic [17:0]                  norm_x,
    input  wire logic [17:0]                  norm_y,
    input  wire logic [17:0]                  norm_z,
    output logic                              q_valid,
    input  wire logic                         q_pop,
    output vwht_pkg::req_t                    q_data
);
    import vwht_pkg::*;

    localparam logic [1:0] ROUNDS_PER_STEP = 2'd3;

    logic                busy_reg, busy_next;
    logic [1:0]          step_reg, step_next;
    logic [31:0]         hx_reg, hx_next, hy_reg, hy_next, hz_reg, hz_next;
    req_t                cur_reg, cur_next;
    req_t                push_req;
    logic [HB_W-1:0]     bits_use;
    logic [HASH_BITS-1:0] mask;
    logic [31:0]         ax, ay, az, hsum;

    req_t                fifo_reg [2];
    logic                wp_reg, rp_reg;
    logic [1:0]          cnt_reg;
    logic                push;

    always_comb
    begin
        ax = hx_reg;
        ay = hy_reg;
        az = hz_reg;
        for (int i = 0; i < 3; i++)
        begin
            ax = mix_round(ax);
            ay = mix_round(ay);
            az = mix_round(az);
        end
    end

    always_comb
    begin
        if (hash_bits < HB_W'(2))
        begin
            bits_use = HB_W'(2);
        end
        else if (hash_bits > HB_W'(HASH_BITS))
        begin
            bits_use = HB_W'(HASH_BITS);
        end
        else
        begin
            bits_use = hash_bits;
        end
        mask = HASH_BITS'((32'd1 << bits_use) - 32'd1);
        hsum = ax ^ ay ^ az;
        push_req        = cur_reg;
        push_req.bucket = hsum[HASH_BITS-1:0] & mask;
    end

    assign in_ready = !busy_reg;
    assign push     = busy_reg && (step_reg == ROUNDS_PER_STEP - 2'd1) && (cnt_reg != 2'd2);

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        hx_next   = hx_reg;
        hy_next   = hy_reg;
        hz_next   = hz_reg;
        cur_next  = cur_reg;
        if (in_valid && in_ready)
        begin
            busy_next         = 1'b1;
            step_next         = 2'd0;
            hx_next           = pos_x;
            hy_next           = pos_y;
            hz_next           = pos_z;
            cur_next.new_mesh = new_mesh;
            cur_next.bucket   = '0;
            cur_next.px       = pos_x;
            cur_next.py       = pos_y;
            cur_next.pz       = pos_z;
            cur_next.uv       = {tex_v, tex_u};
            cur_next.nrm      = {norm_z, norm_y, norm_x};
        end
        else if (busy_reg && step_reg != ROUNDS_PER_STEP - 2'd1)
        begin
            step_next = step_reg + 2'd1;
            hx_next   = ax;
            hy_next   = ay;
            hz_next   = az;
        end
        else if (push)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        hx_reg  <= hx_next;
        hy_reg  <= hy_next;
        hz_reg  <= hz_next;
        cur_reg <= cur_next;
        if (push)
        begin
            fifo_reg[wp_reg] <= push_req;
        end
    end

    assign q_valid = cnt_reg != 2'd0;
    assign q_data  = fifo_reg[rp_reg];
endmodule
`default_nettype wire

// ----- src/vwht_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vwht_back
// Walks the bucket chain, compares entries, appends on a miss unless the store
// is full, and holds the result in an output register.
// ----------------------------------------------------------------------------
module vwht_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    output logic                               q_pop,
    input  wire vwht_pkg::req_t                q_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [vwht_pkg::OUT_IDX_W-1:0]     vertex_index,
    output logic                               was_new,
    output logic                               store_full
);
    import vwht_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HEAD  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_DOT   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;
    localparam logic [2:0] S_CLEAR = 3'd6;
    localparam logic [2:0] S_WIPE  = 3'd7;

    localparam int ENTRY_W = 3 * 32 + 64 + 3 * NRM_W + LINK_W;
    // each bucket head carries the mesh epoch it was written in
    localparam int EPOCH_W = 8;
    localparam int HEAD_W  = LINK_W + EPOCH_W;

    logic [2:0]            state_reg, state_next;
    req_t                  req_reg;
    logic [LINK_W-1:0]     link_reg, link_next;
    logic [LINK_W-1:0]     head_val_reg;
    logic [LINK_W-1:0]     count_reg;
    logic [LINK_W-1:0]     probes_reg;
    logic [EPOCH_W-1:0]    epoch_reg;
    logic [HASH_BITS-1:0]  wipe_reg;
    logic                  booting_reg;
    logic                  out_valid_reg;
    logic [OUT_IDX_W-1:0]  idx_reg;
    logic                  new_reg, full_reg;
    logic signed [DOT_W-1:0] p0_reg, p1_reg, p2_reg;

    logic                  head_we;
    logic [HASH_BITS-1:0]  head_waddr;
    logic [HEAD_W-1:0]     head_rdata, head_wdata;
    logic [LINK_W-1:0]     head_link;
    logic                  wipe_last;
    logic                  ent_we;
    logic [ENTRY_W-1:0]    ent_wdata, ent_rdata;
    logic [VIDX_W-1:0]     ent_raddr;
    logic [31:0]           ex, ey, ez;
    logic [63:0]           euv;
    logic [3*NRM_W-1:0]    enrm;
    logic [LINK_W-1:0]     enext;
    logic signed [DOT_W-1:0] dsum;
    logic                  walk_on;

    vwht_ram #(.WIDTH(HEAD_W), .DEPTH(BUCKETS)) u_head (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (req_reg.bucket),
        .rdata (head_rdata)
    );

    vwht_ram #(.WIDTH(ENTRY_W), .DEPTH(VERTEX_DEPTH)) u_entry (
        .clk   (clk),
        .we    (ent_we),
        .waddr (count_reg[VIDX_W-1:0]),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    assign {enext, enrm, euv, ez, ey, ex} = ent_rdata;
    assign ent_raddr  = link_reg[VIDX_W-1:0] - VIDX_W'(1);
    // a head from an older epoch reads as an empty bucket
    assign head_link  = (head_rdata[HEAD_W-1:LINK_W] == epoch_reg) ?
                        head_rdata[LINK_W-1:0] : '0;
    assign wipe_last  = wipe_reg == HASH_BITS'(BUCKETS - 1);
    assign head_waddr = (state_reg == S_WIPE) ? wipe_reg : req_reg.bucket;
    assign head_wdata = (state_reg == S_WIPE) ? '0 : {epoch_reg, count_reg + LINK_W'(1)};
    assign ent_wdata  = {head_val_reg, req_reg.nrm, req_reg.uv, req_reg.pz, req_reg.py,
                         req_reg.px};
    assign dsum       = p0_reg + p1_reg + p2_reg;
    assign walk_on    = (link_reg != '0) && (link_reg <= LINK_W'(VERTEX_DEPTH))
                        && (probes_reg < LINK_W'(VERTEX_DEPTH));

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    logic appendable;
    assign appendable = count_reg < LINK_W'(VERTEX_DEPTH);
    assign ent_we     = (state_reg == S_DONE) && appendable;
    assign head_we    = ent_we || (state_reg == S_WIPE);

    always_comb
    begin
        state_next = state_reg;
        link_next  = link_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                // epoch wraps: wipe every head, then come back here
                if (req_reg.new_mesh && epoch_reg == '1)
                begin
                    state_next = S_WIPE;
                end
                else
                begin
                    state_next = S_HEAD;
                end
            end
            S_WIPE:
            begin
                if (wipe_last)
                begin
                    state_next = booting_reg ? S_IDLE : S_CLEAR;
                end
            end
            S_HEAD:
            begin
                link_next  = head_link;
                state_next = S_READ;
            end
            S_READ:
            begin
                if (walk_on)
                begin
                    state_next = S_CMP;
                end
                else if (out_valid_reg)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CMP:
            begin
                if (ex == req_reg.px && ey == req_reg.py && ez == req_reg.pz
                    && euv == req_reg.uv)
                begin
                    state_next = S_DOT;
                end
                else
                begin
                    link_next  = enext;
                    state_next = S_READ;
                end
            end
            S_DOT:
            begin
                if (dsum > DOT_LOW && dsum < DOT_HIGH)
                begin
                    if (!out_valid_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    link_next  = enext;
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_WIPE;
            count_reg     <= '0;
            epoch_reg     <= '0;
            wipe_reg      <= '0;
            booting_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            probes_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    probes_reg <= '0;
                    if (req_reg.new_mesh)
                    begin
                        epoch_reg <= epoch_reg + EPOCH_W'(1);
                        count_reg <= '0;
                    end
                end
                S_WIPE:
                begin
                    wipe_reg <= wipe_reg + HASH_BITS'(1);
                    if (wipe_last)
                    begin
                        booting_reg <= 1'b0;
                    end
                end
                S_CMP:
                begin
                    if (state_next == S_READ)
                    begin
                        probes_reg <= probes_reg + LINK_W'(1);
                    end
                end
                S_DOT:
                begin
                    if (state_next == S_READ)
                    begin
                        probes_reg <= probes_reg + LINK_W'(1);
                    end
                    else if (state_next == S_IDLE)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    if (appendable)
                    begin
                        count_reg <= count_reg + LINK_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            req_reg <= q_data;
        end
        else if (state_reg == S_CLEAR)
        begin
            req_reg.new_mesh <= 1'b0;
        end
        if (state_reg == S_HEAD)
        begin
            head_val_reg <= head_link;
        end
        link_reg <= link_next;
        p0_reg <= DOT_W'($signed(enrm[NRM_W-1:0]) * $signed(req_reg.nrm[NRM_W-1:0]));
        p1_reg <= DOT_W'($signed(enrm[2*NRM_W-1:NRM_W])
                         * $signed(req_reg.nrm[2*NRM_W-1:NRM_W]));
        p2_reg <= DOT_W'($signed(enrm[3*NRM_W-1:2*NRM_W])
                         * $signed(req_reg.nrm[3*NRM_W-1:2*NRM_W]));
        if (state_reg == S_DOT && state_next == S_IDLE)
        begin
            idx_reg  <= OUT_IDX_W'(ent_raddr);
            new_reg  <= 1'b0;
            full_reg <= 1'b0;
        end
        else if (state_reg == S_DONE)
        begin
            idx_reg  <= appendable ? OUT_IDX_W'(count_reg) : '0;
            new_reg  <= appendable;
            full_reg <= !appendable;
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = idx_reg;
    assign was_new      = new_reg;
    assign store_full   = full_reg;
endmodule
`default_nettype wire

// ----- src/vertex_weld_hash_table.sv -----
// Flow: the front takes no new vertex until the current one is hashed and
// queued; the back end pops a request only when idle, and sets the rate once a
// chain is walked.
// Reset: asynchronous active low; sets hash_bits to 10, then a pass clears the
// bucket heads; every 256th new mesh repeats it.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_weld_hash_table
// Vertex deduplication through a chained hash table.
// ----------------------------------------------------------------------------
module vertex_weld_hash_table (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [vwht_pkg::HB_W-1:0]  cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       new_mesh,
    input  wire logic [31:0]                pos_x,
    input  wire logic [31:0]                pos_y,
    input  wire logic [31:0]                pos_z,
    input  wire logic [31:0]                tex_u,
    input  wire logic [31:0]                tex_v,
    input  wire logic [17:0]                norm_x,
    input  wire logic [17:0]                norm_y,
    input  wire logic [17:0]                norm_z,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [vwht_pkg::OUT_IDX_W-1:0]  vertex_index,
    output logic                            was_new,
    output logic                            store_full
);
    import vwht_pkg::*;

    logic [HB_W-1:0] hash_bits_reg;
    logic            q_valid, q_pop;
    req_t            q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_bits_reg <= HB_W'(10);
        end
        else if (cfg_we)
        begin
            hash_bits_reg <= cfg_wdata;
        end
    end

    vwht_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hash_bits (hash_bits_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .new_mesh  (new_mesh),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .tex_u     (tex_u),
        .tex_v     (tex_v),
        .norm_x    (norm_x),
        .norm_y    (norm_y),
        .norm_z    (norm_z),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data)
    );

    vwht_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_data       (q_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vertex_index (vertex_index),
        .was_new      (was_new),
        .store_full   (store_full)
    );
endmodule
`default_nettype wire

// ----- tb/vertex_weld_hash_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_weld_hash_table_tb
// Drives vertices through the weld table with random handshake gaps and
// checks every returned index, new flag and full flag against a predictor.
// ----------------------------------------------------------------------------
module vertex_weld_hash_table_tb;
    import vwht_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [HB_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic new_mesh = 1'b0;
    logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
    logic [17:0] norm_x = '0, norm_y = '0, norm_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [OUT_IDX_W-1:0] vertex_index;
    logic was_new;
    logic store_full;

    typedef struct {
        logic [OUT_IDX_W-1:0] index;
        logic                 fresh;
        logic                 full;
    } weld_result_t;

    weld_result_t pending_results[$];

    // predictor copy of the table
    logic [HB_W-1:0] model_bits;
    logic [LINK_W-1:0] model_head[BUCKETS];
    logic [LINK_W-1:0] model_next[VERTEX_DEPTH];
    logic [31:0] model_x[VERTEX_DEPTH], model_y[VERTEX_DEPTH], model_z[VERTEX_DEPTH];
    logic [63:0] model_uv[VERTEX_DEPTH];
    logic [53:0] model_nrm[VERTEX_DEPTH];
    int model_count;

    int error_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int hit_count = 0;
    int full_count = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit stall_recv = 1'b0;

    // library of positions for reuse, so that hits happen
    logic [31:0] lib_p[64][5];
    logic [17:0] lib_n[64][3];

    vertex_weld_hash_table dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .new_mesh(new_mesh),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .vertex_index(vertex_index), .was_new(was_new), .store_full(store_full)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] position_hash(input logic [31:0] w);
        logic [31:0] v;
        v = w;
        for (int r = 1; r < 10; r++)
            v = v + 32'h1234_5678 + ((v << 5) | {{27{v[31]}}, v[31:27]});
        return v;
    endfunction

    function automatic longint normal_dot(input logic [53:0] a, input logic [53:0] b);
        longint s;
        s = 0;
        for (int k = 0; k < 3; k++)
            s += longint'($signed(a[18*k +: 18])) * longint'($signed(b[18*k +: 18]));
        return s;
    endfunction

    function automatic weld_result_t predict_weld(input logic nm, input logic [31:0] px,
        input logic [31:0] py, input logic [31:0] pz, input logic [63:0] uv,
        input logic [53:0] nrm);
        weld_result_t r;
        int bits;
        int h;
        int link;
        int probes;
        int e;
        longint s;
        if (nm)
        begin
            foreach (model_head[i]) model_head[i] = '0;
            model_count = 0;
        end
        bits = model_bits;
        if (bits < 2) bits = 2;
        if (bits > HASH_BITS) bits = HASH_BITS;
        h = int'((position_hash(px) ^ position_hash(py) ^ position_hash(pz))
                 & ((32'd1 << bits) - 1));
        link = model_head[h];
        probes = 0;
        while (link != 0 && link <= VERTEX_DEPTH && probes < VERTEX_DEPTH)
        begin
            e = link - 1;
            if (model_x[e] == px && model_y[e] == py && model_z[e] == pz &&
                model_uv[e] == uv)
            begin
                s = normal_dot(model_nrm[e], nrm);
                if (s > 64'shfff0_0000 && s < 64'sh1_0010_0000)
                begin
                    r.index = e[OUT_IDX_W-1:0];
                    r.fresh = 1'b0;
                    r.full = 1'b0;
                    return r;
                end
            end
            link = model_next[e];
            probes++;
        end
        if (model_count >= VERTEX_DEPTH)
        begin
            r.index = '0;
            r.fresh = 1'b0;
            r.full = 1'b1;
            return r;
        end
        e = model_count;
        model_x[e] = px;
        model_y[e] = py;
        model_z[e] = pz;
        model_uv[e] = uv;
        model_nrm[e] = nrm;
        model_next[e] = model_head[h];
        model_head[h] = LINK_W'(e + 1);
        model_count = e + 1;
        r.index = e[OUT_IDX_W-1:0];
        r.fresh = 1'b1;
        r.full = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (result %0d)",
                 what, got, want, checked_count);
        error_count++;
    endtask

    task automatic send_vertex(input logic nm, input logic [31:0] px, input logic [31:0] py,
        input logic [31:0] pz, input logic [31:0] u, input logic [31:0] v,
        input logic [17:0] nx, input logic [17:0] ny, input logic [17:0] nz);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        // drop valid only when a gap comes first, so back-to-back requests keep it high
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        new_mesh <= nm;
        pos_x <= px; pos_y <= py; pos_z <= pz;
        tex_u <= u; tex_v <= v;
        norm_x <= nx; norm_y <= ny; norm_z <= nz;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(predict_weld(nm, px, py, pz, {v, u}, {nz, ny, nx}));
        sent_count++;
    endtask

    task automatic send_library(input int k, input logic nm, input bit tweak_normal);
        logic [17:0] nx;
        nx = lib_n[k][0];
        if (tweak_normal) nx = nx + 18'($urandom_range(0, 600)) - 18'd300;
        send_vertex(nm, lib_p[k][0], lib_p[k][1], lib_p[k][2], lib_p[k][3], lib_p[k][4],
                    nx, lib_n[k][1], lib_n[k][2]);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_hash_bits(input logic [HB_W-1:0] val);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_bits = val;
    endtask

    // checker: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result, index %0d", vertex_index);
                error_count++;
            end
            else
            begin
                weld_result_t w;
                w = pending_results.pop_front();
                if (vertex_index !== w.index)
                    report_mismatch("vertex_index", int'(vertex_index), int'(w.index));
                if (was_new !== w.fresh)
                    report_mismatch("was_new", int'(was_new), int'(w.fresh));
                if (store_full !== w.full)
                    report_mismatch("store_full", int'(store_full), int'(w.full));
                if (!w.fresh && !w.full) hit_count++;
                if (w.full) full_count++;
            end
            checked_count++;
        end
    end

    // receiver: random stall per result when stall_recv is set, long hold-off on request
    initial
    begin
        int wait_cycles;
        forever
        begin
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            wait_cycles = stall_recv ? $urandom_range(0, 5) : 0;
            if (wait_cycles != 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_directed_extremes();
        send_vertex(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h8000_0000,
                    32'h7fff_ffff, 18'h10000, 18'h0, 18'h0);
        // same vertex again: vertex 0 must be found
        send_vertex(1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h8000_0000,
                    32'h7fff_ffff, 18'h10000, 18'h0, 18'h0);
        send_vertex(1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                    32'hffff_ffff, 18'h30000, 18'h0, 18'h0);
        send_vertex(1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                    32'hffff_ffff, 18'h30000, 18'h0, 18'h0);
        // dot product right on either bound of the first entry: no match with it
        send_vertex(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 18'h10000, 18'h0, 18'h0);
        send_vertex(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 18'h0fff0, 18'h0, 18'h0);
        send_vertex(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 18'h10010, 18'h0, 18'h0);
        send_vertex(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 18'h0fff1, 18'h0, 18'h0);
        // out-of-range normal patterns
        send_vertex(1'b0, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 18'h1ffff, 18'h20000, 18'h3ffff);
        send_vertex(1'b0, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 18'h1ffff, 18'h20000, 18'h3ffff);
        send_vertex(1'b0, 32'h1, 32'h2, 32'h3, 32'h4, 32'h6, 18'h0, 18'h10000, 18'h0);
        // new mesh drops everything
        send_vertex(1'b1, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 18'h1ffff, 18'h20000, 18'h3ffff);
    endtask

    task automatic test_fill_store();
        // fill past the depth with few buckets so chains grow; keep vertices distinct
        send_vertex(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 18'h10000, 18'h0, 18'h0);
        for (int i = 1; i < VERTEX_DEPTH + 6; i++)
            send_vertex(1'b0, 32'(i), 32'd0, 32'd0, 32'd0, 32'd0, 18'h10000, 18'h0, 18'h0);
        // hits on the oldest and newest stored vertices
        send_vertex(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 18'h10000, 18'h0, 18'h0);
        send_vertex(1'b0, 32'd1023, 32'd0, 32'd0, 32'd0, 32'd0, 18'h10000, 18'h0, 18'h0);
    endtask

    task automatic test_random_welds(input int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 63);
            case ($urandom_range(0, 9))
                0: send_vertex($urandom_range(0, 40) == 0, $urandom, $urandom, $urandom,
                               $urandom, $urandom, 18'($urandom), 18'($urandom), 18'($urandom));
                1: send_library(k, 1'b0, 1'b1);
                2:
                begin
                    // refresh one library slot with new content
                    for (int j = 0; j < 5; j++) lib_p[k][j] = $urandom;
                    lib_n[k][$urandom_range(0, 2)] = 18'h10000;
                    send_library(k, 1'b0, 1'b0);
                end
                default: send_library(k, $urandom_range(0, 60) == 0, 1'b0);
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 40; i++) send_library(i, 1'b0, 1'b0);
    endtask

    initial
    begin
        model_bits = 4'd10;
        model_count = 0;
        foreach (model_head[i]) model_head[i] = '0;
        for (int k = 0; k < 64; k++)
        begin
            for (int j = 0; j < 5; j++)
                lib_p[k][j] = (k < 16) ? 32'($urandom_range(0, 3)) << 16 : $urandom;
            for (int j = 0; j < 3; j++) lib_n[k][j] = 18'h0;
            lib_n[k][k % 3] = (k % 2) ? 18'h30000 : 18'h10000;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        stall_recv = 1'b1;
        write_hash_bits(4'd2);
        test_fill_store();
        write_hash_bits(4'd0);
        test_random_welds(150);
        write_hash_bits(4'd15);
        test_backpressure();
        test_random_welds(150);
        write_hash_bits(4'd10);
        test_random_welds(150);
        write_hash_bits(4'd5);
        stall_recv = 1'b0;
        test_random_welds(100);
        stall_recv = 1'b1;
        test_random_welds(70);
        drain_results();

        $display("%0d vertices sent, %0d results checked: %0d welded hits, %0d store-full",
                 sent_count, checked_count, hit_count, full_count);
        $display("hash widths 0, 2, 5, 10 and 15 used, with a full store and a long stall");
        if (error_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
